@@ hw/rtl/afr_pkg.sv @@
// Package for the ASH frame receiver: line byte codes, status and frame type codes,
// the result record and the bytewise CRC and LFSR step functions.
// Depends on nothing; the frame core, the top level and the bench refer to it.
package afr_pkg;

   localparam int unsigned MAX_PAYLOAD_DEFAULT   = 132;
   localparam int unsigned COUNTER_WIDTH_DEFAULT = 16;

   localparam logic [7:0] BYTE_CANCEL     = 8'h1A;
   localparam logic [7:0] BYTE_SUBSTITUTE = 8'h18;
   localparam logic [7:0] BYTE_XON        = 8'h11;
   localparam logic [7:0] BYTE_XOFF       = 8'h13;
   localparam logic [7:0] BYTE_FLAG       = 8'h7E;
   localparam logic [7:0] BYTE_ESCAPE     = 8'h7D;
   localparam logic [7:0] ESCAPE_FLIP     = 8'h20;

   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] CRC_SEED_INIT = 16'hFFFF;
   localparam logic [7:0]  LFSR_SEED     = 8'h42;
   localparam logic [7:0]  LFSR_TAPS     = 8'hB8;

   localparam logic [2:0] CTL_CLASS_ACK = 3'b100;
   localparam logic [2:0] CTL_CLASS_NAK = 3'b101;
   localparam logic [7:0] CTL_RST       = 8'hC0;
   localparam logic [7:0] CTL_RSTACK    = 8'hC1;
   localparam logic [7:0] CTL_ERROR     = 8'hC2;

   localparam logic [2:0] STATUS_GOOD        = 3'd0;
   localparam logic [2:0] STATUS_ESCAPE_END  = 3'd1;
   localparam logic [2:0] STATUS_TOO_SHORT   = 3'd2;
   localparam logic [2:0] STATUS_TOO_LONG    = 3'd3;
   localparam logic [2:0] STATUS_CRC_ERROR   = 3'd4;
   localparam logic [2:0] STATUS_BAD_CONTROL = 3'd5;

   localparam logic [2:0] TYPE_DATA   = 3'd0;
   localparam logic [2:0] TYPE_ACK    = 3'd1;
   localparam logic [2:0] TYPE_NAK    = 3'd2;
   localparam logic [2:0] TYPE_RST    = 3'd3;
   localparam logic [2:0] TYPE_RSTACK = 3'd4;
   localparam logic [2:0] TYPE_ERROR  = 3'd5;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [2:0]  status;
      logic [2:0]  frame_type;
      logic [2:0]  frame_number;
      logic [2:0]  ack_number;
      logic        retransmitted;
      logic        not_ready;
      logic [7:0]  reset_code;
      logic [7:0]  payload_length;
      logic [15:0] discarded_count;
      logic [15:0] cancelled_count;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } core_out_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic logic [7:0] lfsr_next(input logic [7:0] l);
      return l[0] ? ({1'b0, l[7:1]} ^ LFSR_TAPS) : {1'b0, l[7:1]};
   endfunction

endpackage

@@ hw/rtl/afr_channels.sv @@
// Handshake channels of the ASH frame receiver: raw byte input, result output and
// the CRC seed write port. Each carries valid, ready and its payload.
// Depends on nothing.
interface afr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface afr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic [2:0]  status;
   logic [2:0]  frame_type;
   logic [2:0]  frame_number;
   logic [2:0]  ack_number;
   logic        retransmitted;
   logic        not_ready;
   logic [7:0]  reset_code;
   logic [7:0]  payload_length;
   logic [15:0] discarded_count;
   logic [15:0] cancelled_count;
   modport source (output valid, output kind, output payload_byte, output status,
                   output frame_type, output frame_number, output ack_number,
                   output retransmitted, output not_ready, output reset_code,
                   output payload_length, output discarded_count,
                   output cancelled_count, input ready);
   modport sink (input valid, input kind, input payload_byte, input status,
                 input frame_type, input frame_number, input ack_number,
                 input retransmitted, input not_ready, input reset_code,
                 input payload_length, input discarded_count,
                 input cancelled_count, output ready);
endinterface

interface afr_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] crc_seed;
   modport source (output valid, output crc_seed, input ready);
   modport sink (input valid, input crc_seed, output ready);
endinterface

@@ hw/rtl/afr_frame_core.sv @@
// Frame state of the ASH frame receiver: unescaping, CRC, two-byte hold, LFSR
// derandomising and the end-of-frame report, one line byte per step.
// Depends on afr_pkg.
module afr_frame_core #(
   parameter int unsigned MAX_PAYLOAD   = afr_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int unsigned COUNTER_WIDTH = afr_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic [15:0]          crc_seed,
   output afr_pkg::core_out_type core_out
);

   localparam int unsigned MAX_BODY    = MAX_PAYLOAD + 3;
   localparam int unsigned STUFF_LIMIT = 2 * MAX_BODY;
   localparam int unsigned CW          = $clog2(STUFF_LIMIT + 1);

   logic [CW-1:0]            stuffed_ff, stuffed_in;
   logic [CW-1:0]            body_ff, body_in;
   logic                     escape_ff, escape_in;
   logic [15:0]              crc_ff, crc_in;
   logic [7:0]               control_ff, control_in;
   logic [7:0]               hold0_ff, hold0_in;
   logic [7:0]               hold1_ff, hold1_in;
   logic [7:0]               lfsr_ff, lfsr_in;
   logic [7:0]               code_ff, code_in;
   logic [COUNTER_WIDTH-1:0] discard_ff, discard_in;
   logic [COUNTER_WIDTH-1:0] cancel_ff, cancel_in;

   logic                     is_cancel, is_flow, is_flag;
   logic                     body_en, clear_frame;
   logic [7:0]               body_val;
   logic [2:0]               status;
   afr_pkg::result_type      res;
   logic                     res_valid;

   assign is_cancel = (data_byte == afr_pkg::BYTE_CANCEL) ||
                      (data_byte == afr_pkg::BYTE_SUBSTITUTE);
   assign is_flow   = (data_byte == afr_pkg::BYTE_XON) || (data_byte == afr_pkg::BYTE_XOFF);
   assign is_flag   = (data_byte == afr_pkg::BYTE_FLAG);

   always_comb begin
      stuffed_in  = stuffed_ff;
      body_in     = body_ff;
      escape_in   = escape_ff;
      crc_in      = crc_ff;
      control_in  = control_ff;
      hold0_in    = hold0_ff;
      hold1_in    = hold1_ff;
      lfsr_in     = lfsr_ff;
      code_in     = code_ff;
      discard_in  = discard_ff;
      cancel_in   = cancel_ff;
      body_en     = 1'b0;
      body_val    = data_byte;
      clear_frame = 1'b0;
      status      = afr_pkg::STATUS_GOOD;
      res         = '0;
      res_valid   = 1'b0;

      if (step) begin
         if (is_cancel) begin
            if (stuffed_ff != '0) begin
               cancel_in = cancel_ff + 1'b1;
            end
            clear_frame = 1'b1;
         end else if (is_flow) begin
            clear_frame = 1'b0;
         end else if (!is_flag) begin
            if (stuffed_ff < CW'(STUFF_LIMIT)) begin
               stuffed_in = stuffed_ff + 1'b1;
               if (escape_ff) begin
                  escape_in = 1'b0;
                  body_en   = 1'b1;
                  body_val  = data_byte ^ afr_pkg::ESCAPE_FLIP;
               end else if (data_byte == afr_pkg::BYTE_ESCAPE) begin
                  escape_in = 1'b1;
               end else begin
                  body_en = 1'b1;
               end
            end
         end else if (stuffed_ff != '0) begin
            res_valid = 1'b1;
            res.kind  = afr_pkg::KIND_REPORT;
            if (escape_ff) begin
               status = afr_pkg::STATUS_ESCAPE_END;
            end else if (body_ff < CW'(3)) begin
               status = afr_pkg::STATUS_TOO_SHORT;
            end else if (body_ff > CW'(MAX_BODY)) begin
               status = afr_pkg::STATUS_TOO_LONG;
            end else if (crc_ff != {hold0_ff, hold1_ff}) begin
               status = afr_pkg::STATUS_CRC_ERROR;
            end else if (!control_ff[7]) begin
               res.frame_type     = afr_pkg::TYPE_DATA;
               res.frame_number   = control_ff[6:4];
               res.ack_number     = control_ff[2:0];
               res.retransmitted  = control_ff[3];
               res.payload_length = 8'(body_ff - CW'(3));
            end else if (control_ff[7:5] == afr_pkg::CTL_CLASS_ACK ||
                         control_ff[7:5] == afr_pkg::CTL_CLASS_NAK) begin
               res.frame_type = (control_ff[7:5] == afr_pkg::CTL_CLASS_ACK) ?
                                afr_pkg::TYPE_ACK : afr_pkg::TYPE_NAK;
               res.ack_number = control_ff[2:0];
               res.not_ready  = control_ff[3];
            end else if (control_ff == afr_pkg::CTL_RST) begin
               res.frame_type = afr_pkg::TYPE_RST;
            end else if (control_ff == afr_pkg::CTL_RSTACK ||
                         control_ff == afr_pkg::CTL_ERROR) begin
               res.frame_type = (control_ff == afr_pkg::CTL_RSTACK) ?
                                afr_pkg::TYPE_RSTACK : afr_pkg::TYPE_ERROR;
               if (body_ff >= CW'(5)) begin
                  res.reset_code = code_ff;
               end
            end else begin
               status = afr_pkg::STATUS_BAD_CONTROL;
            end
            if (status != afr_pkg::STATUS_GOOD) begin
               res.frame_type     = '0;
               res.frame_number   = '0;
               res.ack_number     = '0;
               res.retransmitted  = 1'b0;
               res.not_ready      = 1'b0;
               res.reset_code     = '0;
               res.payload_length = '0;
               discard_in         = discard_ff + 1'b1;
            end
            res.status          = status;
            res.discarded_count = 16'(discard_in);
            res.cancelled_count = 16'(cancel_ff);
            clear_frame         = 1'b1;
         end
      end

      if (body_en) begin
         if (body_ff >= CW'(2)) begin
            crc_in = afr_pkg::crc_byte(crc_ff, hold0_ff);
            if (body_ff == CW'(2)) begin
               control_in = hold0_ff;
            end else begin
               if (body_ff == CW'(4)) begin
                  code_in = hold0_ff;
               end
               if (!control_ff[7] && body_ff <= CW'(MAX_PAYLOAD + 2)) begin
                  res_valid        = 1'b1;
                  res.kind         = afr_pkg::KIND_PAYLOAD;
                  res.payload_byte = hold0_ff ^ lfsr_ff;
                  lfsr_in          = afr_pkg::lfsr_next(lfsr_ff);
               end
            end
            hold0_in = hold1_ff;
            hold1_in = body_val;
         end else if (body_ff[0]) begin
            hold1_in = body_val;
         end else begin
            hold0_in = body_val;
         end
         body_in = body_ff + 1'b1;
      end

      if (clear_frame) begin
         stuffed_in = '0;
         body_in    = '0;
         escape_in  = 1'b0;
         crc_in     = crc_seed;
         control_in = '0;
         hold0_in   = '0;
         hold1_in   = '0;
         lfsr_in    = afr_pkg::LFSR_SEED;
         code_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stuffed_ff <= '0;
         body_ff    <= '0;
         escape_ff  <= 1'b0;
         crc_ff     <= afr_pkg::CRC_SEED_INIT;
         control_ff <= '0;
         hold0_ff   <= '0;
         hold1_ff   <= '0;
         lfsr_ff    <= afr_pkg::LFSR_SEED;
         code_ff    <= '0;
         discard_ff <= '0;
         cancel_ff  <= '0;
      end else begin
         stuffed_ff <= stuffed_in;
         body_ff    <= body_in;
         escape_ff  <= escape_in;
         crc_ff     <= crc_in;
         control_ff <= control_in;
         hold0_ff   <= hold0_in;
         hold1_ff   <= hold1_in;
         lfsr_ff    <= lfsr_in;
         code_ff    <= code_in;
         discard_ff <= discard_in;
         cancel_ff  <= cancel_in;
      end
   end

   assign core_out.valid  = res_valid;
   assign core_out.result = res;

endmodule

@@ hw/rtl/ash_frame_receiver.sv @@
// ASH frame receiver: the top level with the input register, the result register
// and the CRC seed register. Depends on afr_pkg, the afr channel interfaces
// and afr_frame_core.
//
// Raw line bytes enter on the req channel, one item per handshake. Each byte
// gives no result or one result on the rsp channel: a tentative payload byte
// (kind 0) as it leaves the two-byte CRC hold of a data frame, or one
// end-of-frame report (kind 1) at a flag that closes a non-empty frame.
// Payload bytes of a frame whose report shows a bad status are to be dropped
// by the consumer.
// A byte is registered on acceptance and processed when the result register is
// free or being read; its result is registered and presented on the rsp channel.
// One byte per cycle is sustained while the rsp side takes results; the whole
// frame step is one pass of logic between the input register and the result
// register. The csr channel writes the CRC seed, loaded when a frame is closed by
// a flag or cancelled; it is always ready. Reset clears the frame state, both
// counters and sets the seed to all ones. While a result waits for the rsp side,
// the next byte still fills the input register; only then does req ready drop.
module ash_frame_receiver #(
   parameter int unsigned MAX_PAYLOAD   = afr_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int unsigned COUNTER_WIDTH = afr_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   afr_req_if.sink   req_chan,
   afr_rsp_if.source rsp_chan,
   afr_csr_if.sink   csr_chan
);

   logic                  req_valid_ff, req_valid_in;
   logic [7:0]            req_byte_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   afr_pkg::result_type   rsp_data_ff;
   logic [15:0]           seed_ff;
   logic                  advance;
   logic                  req_take;
   afr_pkg::core_out_type core_out;

   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = advance ? core_out.valid :
                         (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   afr_frame_core #(
      .MAX_PAYLOAD   (MAX_PAYLOAD),
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (req_byte_ff),
      .crc_seed  (seed_ff),
      .core_out  (core_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= afr_pkg::CRC_SEED_INIT;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            seed_ff <= csr_chan.crc_seed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_byte_ff <= req_chan.data_byte;
      end
      if (advance && core_out.valid) begin
         rsp_data_ff <= core_out.result;
      end
   end

   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.kind            = rsp_data_ff.kind;
   assign rsp_chan.payload_byte    = rsp_data_ff.payload_byte;
   assign rsp_chan.status          = rsp_data_ff.status;
   assign rsp_chan.frame_type      = rsp_data_ff.frame_type;
   assign rsp_chan.frame_number    = rsp_data_ff.frame_number;
   assign rsp_chan.ack_number      = rsp_data_ff.ack_number;
   assign rsp_chan.retransmitted   = rsp_data_ff.retransmitted;
   assign rsp_chan.not_ready       = rsp_data_ff.not_ready;
   assign rsp_chan.reset_code      = rsp_data_ff.reset_code;
   assign rsp_chan.payload_length  = rsp_data_ff.payload_length;
   assign rsp_chan.discarded_count = rsp_data_ff.discarded_count;
   assign rsp_chan.cancelled_count = rsp_data_ff.cancelled_count;

endmodule

@@ sim/ash_frame_receiver_test.sv @@
// Self-checking bench for ash_frame_receiver: a bit-true model predicts payload bytes
// and end-of-frame reports on the result channel; directed rows fix some reports.
// Depends on afr_pkg, the afr channel interfaces and the receiver RTL.
module ash_frame_receiver_test;
   timeunit 1ns;
   timeprecision 1ps;

   import afr_pkg::*;

   localparam int unsigned PAYLOAD_LIMIT   = MAX_PAYLOAD_DEFAULT;
   localparam int unsigned BODY_LIMIT      = PAYLOAD_LIMIT + 3;
   localparam int unsigned STUFF_LIMIT     = 2 * BODY_LIMIT;
   localparam int          PHASE_ITEMS     = 205;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam result_type  NO_REPORT       = '0;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       typed;
      result_type want;
   } line_row_type;

   logic clock = 1'b0;
   logic reset;

   afr_req_if req_chan ();
   afr_rsp_if rsp_chan ();
   afr_csr_if csr_chan ();

   ash_frame_receiver uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Frame receiver model state.
   logic [15:0] model_seed;
   logic [15:0] frame_crc;
   logic [8:0]  stuffed_n;
   logic [8:0]  body_n;
   bit          escape_open;
   logic [7:0]  ctl_byte;
   logic [7:0]  held [2];
   logic [7:0]  scrambler;
   logic [7:0]  code_held;
   logic [15:0] discards;
   logic [15:0] cancels;

   result_type   expected_results [$];
   line_row_type directed_rows [$];

   int failures        = 0;
   int results_checked = 0;
   int reports_checked = 0;
   int line_bytes_sent = 0;
   int seed_settings   = 0;
   int req_idle_pct    = 26;
   int rsp_idle_pct    = 26;
   bit hold_off_request = 1'b0;

   function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic void restart_frame();
      stuffed_n   = '0;
      body_n      = '0;
      escape_open = 1'b0;
      frame_crc   = model_seed;
      ctl_byte    = '0;
      held[0]     = '0;
      held[1]     = '0;
      scrambler   = LFSR_SEED;
      code_held   = '0;
   endfunction

   function automatic result_type report_of(input logic [2:0] st, input logic [15:0] d,
                                            input logic [15:0] c);
      result_type r;
      r                 = '0;
      r.kind            = KIND_REPORT;
      r.status          = st;
      r.discarded_count = d;
      r.cancelled_count = c;
      return r;
   endfunction

   function automatic void add_row(input logic [7:0] b, input logic typed,
                                   input result_type want);
      line_row_type row;
      row.line_byte = b;
      row.typed     = typed;
      row.want      = want;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic bit model_line_byte(input logic [7:0] b, output result_type r);
      logic [7:0] body_val;
      logic [7:0] leaving;
      logic [8:0] k;
      logic [2:0] st;
      bit         produced;
      r        = '0;
      produced = 1'b0;
      body_val = b;
      if (b == BYTE_CANCEL || b == BYTE_SUBSTITUTE) begin
         if (stuffed_n != 0) cancels = cancels + 16'd1;
         restart_frame();
         return 1'b0;
      end
      if (b == BYTE_XON || b == BYTE_XOFF) return 1'b0;
      if (b != BYTE_FLAG) begin
         if (stuffed_n >= STUFF_LIMIT) return 1'b0;
         stuffed_n = stuffed_n + 9'd1;
         if (escape_open) begin
            escape_open = 1'b0;
            body_val    = b ^ ESCAPE_FLIP;
         end else if (b == BYTE_ESCAPE) begin
            escape_open = 1'b1;
            return 1'b0;
         end
         if (body_n >= 2) begin
            leaving   = held[0];
            k         = body_n - 9'd2;
            frame_crc = crc_step(frame_crc, leaving);
            if (k == 0) begin
               ctl_byte = leaving;
            end else begin
               if (k == 2) code_held = leaving;
               if (!ctl_byte[7] && k <= PAYLOAD_LIMIT) begin
                  r.kind         = KIND_PAYLOAD;
                  r.payload_byte = leaving ^ scrambler;
                  scrambler = scrambler[0] ? ({1'b0, scrambler[7:1]} ^ LFSR_TAPS)
                                           : {1'b0, scrambler[7:1]};
                  produced = 1'b1;
               end
            end
            held[0] = held[1];
            held[1] = body_val;
         end else begin
            held[body_n[0]] = body_val;
         end
         body_n = body_n + 9'd1;
         return produced;
      end
      if (stuffed_n == 0) return 1'b0;
      r.kind = KIND_REPORT;
      st     = STATUS_GOOD;
      if (escape_open) begin
         st = STATUS_ESCAPE_END;
      end else if (body_n < 3) begin
         st = STATUS_TOO_SHORT;
      end else if (body_n > BODY_LIMIT) begin
         st = STATUS_TOO_LONG;
      end else if (frame_crc != {held[0], held[1]}) begin
         st = STATUS_CRC_ERROR;
      end else if (!ctl_byte[7]) begin
         r.frame_type     = TYPE_DATA;
         r.frame_number   = ctl_byte[6:4];
         r.ack_number     = ctl_byte[2:0];
         r.retransmitted  = ctl_byte[3];
         r.payload_length = body_n[7:0] - 8'd3;
      end else if (ctl_byte[7:5] == CTL_CLASS_ACK || ctl_byte[7:5] == CTL_CLASS_NAK) begin
         r.frame_type = (ctl_byte[7:5] == CTL_CLASS_ACK) ? TYPE_ACK : TYPE_NAK;
         r.ack_number = ctl_byte[2:0];
         r.not_ready  = ctl_byte[3];
      end else if (ctl_byte == CTL_RST) begin
         r.frame_type = TYPE_RST;
      end else if (ctl_byte == CTL_RSTACK || ctl_byte == CTL_ERROR) begin
         r.frame_type = (ctl_byte == CTL_RSTACK) ? TYPE_RSTACK : TYPE_ERROR;
         if (body_n >= 5) r.reset_code = code_held;
      end else begin
         st = STATUS_BAD_CONTROL;
      end
      if (st != STATUS_GOOD) begin
         r        = '0;
         r.kind   = KIND_REPORT;
         discards = discards + 16'd1;
      end
      r.status          = st;
      r.discarded_count = discards;
      r.cancelled_count = cancels;
      restart_frame();
      return 1'b1;
   endfunction

   task automatic send_line_byte(input logic [7:0] b, input bit use_typed,
                                 input result_type typed_r);
      result_type predicted;
      bit         produced;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_chan.valid     <= 1'b0;
         req_chan.data_byte <= 8'($urandom_range(0, 255));
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      produced = model_line_byte(b, predicted);
      if (use_typed) begin
         produced  = 1'b1;
         predicted = typed_r;
      end
      if (produced) expected_results = {expected_results, predicted};
      if (b != BYTE_XON && b != BYTE_XOFF) line_bytes_sent++;
   endtask

   task automatic write_crc_seed(input logic [15:0] v);
      @(negedge clock);
      csr_chan.valid    <= 1'b1;
      csr_chan.crc_seed <= v;
      do @(posedge clock); while (!csr_chan.ready);
      model_seed = v;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_frame();
      logic [7:0]  body [$];
      logic [7:0]  line [$];
      logic [7:0]  ctl;
      logic [15:0] crc;
      int          extra;
      int          shape;
      shape = $urandom_range(0, 19);
      if (shape == 0) begin
         repeat ($urandom_range(1, 6)) line = {line, 8'($urandom_range(0, 255))};
         line = {line, BYTE_FLAG};
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               ctl   = 8'($urandom_range(0, 127));
               shape = $urandom_range(0, 39);
               if (shape == 0) extra = PAYLOAD_LIMIT + $urandom_range(1, 6);
               else if (shape == 1) extra = $urandom_range(PAYLOAD_LIMIT - 4, PAYLOAD_LIMIT);
               else if (shape == 2) extra = -1;
               else extra = $urandom_range(0, 12);
            end
            5, 6: begin
               ctl      = 8'($urandom_range(0, 31));
               ctl[7:5] = $urandom_range(0, 1) ? CTL_CLASS_ACK : CTL_CLASS_NAK;
               extra    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            end
            7: begin
               ctl   = CTL_RST;
               extra = 0;
            end
            8: begin
               ctl   = $urandom_range(0, 1) ? CTL_RSTACK : CTL_ERROR;
               extra = $urandom_range(0, 3);
            end
            default: begin
               ctl   = 8'($urandom_range(8'hC3, 8'hFF));
               extra = $urandom_range(0, 2);
            end
         endcase
         body = {body, ctl};
         if (extra < 0) repeat (BODY_LIMIT + 2) body = {body, BYTE_FLAG};
         else repeat (extra) body = {body, 8'($urandom_range(0, 255))};
         crc = model_seed;
         foreach (body[i]) crc = crc_step(crc, body[i]);
         if ($urandom_range(0, 14) == 0)
            body[$urandom_range(0, body.size() - 1)] ^= (8'h01 << $urandom_range(0, 7));
         body = {body, crc[15:8]};
         body = {body, crc[7:0]};
         foreach (body[i]) begin
            if ($urandom_range(0, 39) == 0)
               line = {line, ($urandom_range(0, 1) != 0) ? BYTE_XON : BYTE_XOFF};
            if (body[i] == BYTE_FLAG || body[i] == BYTE_ESCAPE || body[i] == BYTE_XON ||
                body[i] == BYTE_XOFF || body[i] == BYTE_CANCEL ||
                body[i] == BYTE_SUBSTITUTE || $urandom_range(0, 19) == 0) begin
               line = {line, BYTE_ESCAPE};
               line = {line, body[i] ^ ESCAPE_FLIP};
            end else begin
               line = {line, body[i]};
            end
         end
         case ($urandom_range(0, 29))
            0: line = {line, ($urandom_range(0, 1) != 0) ? BYTE_CANCEL : BYTE_SUBSTITUTE};
            1: begin
               line = {line, BYTE_ESCAPE};
               line = {line, BYTE_FLAG};
            end
            default: line = {line, BYTE_FLAG};
         endcase
      end
      foreach (line[i]) send_line_byte(line[i], 1'b0, NO_REPORT);
   endtask

   function automatic int field_differs(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
      if (want === got) return 0;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      result_type seen;
      result_type wanted;
      int         errors;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.kind            = rsp_chan.kind;
         seen.payload_byte    = rsp_chan.payload_byte;
         seen.status          = rsp_chan.status;
         seen.frame_type      = rsp_chan.frame_type;
         seen.frame_number    = rsp_chan.frame_number;
         seen.ack_number      = rsp_chan.ack_number;
         seen.retransmitted   = rsp_chan.retransmitted;
         seen.not_ready       = rsp_chan.not_ready;
         seen.reset_code      = rsp_chan.reset_code;
         seen.payload_length  = rsp_chan.payload_length;
         seen.discarded_count = rsp_chan.discarded_count;
         seen.cancelled_count = rsp_chan.cancelled_count;
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected, kind %0d byte %0h status %0d",
                     $time, seen.kind, seen.payload_byte, seen.status);
            failures++;
         end else begin
            wanted = expected_results.pop_front();
            errors = field_differs("kind", 16'(wanted.kind), 16'(seen.kind))
                   + field_differs("payload_byte", 16'(wanted.payload_byte),
                                   16'(seen.payload_byte))
                   + field_differs("status", 16'(wanted.status), 16'(seen.status))
                   + field_differs("frame_type", 16'(wanted.frame_type),
                                   16'(seen.frame_type))
                   + field_differs("frame_number", 16'(wanted.frame_number),
                                   16'(seen.frame_number))
                   + field_differs("ack_number", 16'(wanted.ack_number),
                                   16'(seen.ack_number))
                   + field_differs("retransmitted", 16'(wanted.retransmitted),
                                   16'(seen.retransmitted))
                   + field_differs("not_ready", 16'(wanted.not_ready),
                                   16'(seen.not_ready))
                   + field_differs("reset_code", 16'(wanted.reset_code),
                                   16'(seen.reset_code))
                   + field_differs("payload_length", 16'(wanted.payload_length),
                                   16'(seen.payload_length))
                   + field_differs("discarded_count", wanted.discarded_count,
                                   seen.discarded_count)
                   + field_differs("cancelled_count", wanted.cancelled_count,
                                   seen.cancelled_count);
            if (errors != 0) failures++;
            results_checked++;
            if (wanted.kind == KIND_REPORT) reports_checked++;
         end
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      line_row_type row;
      logic [15:0]  phase_seed;
      int           phase_end;
      bit           paused;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = 8'h00;
      csr_chan.valid     = 1'b0;
      csr_chan.crc_seed  = 16'h0000;
      model_seed         = CRC_SEED_INIT;
      discards           = '0;
      cancels            = '0;
      restart_frame();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(BYTE_XON, 1'b0, NO_REPORT);
      add_row(BYTE_FLAG, 1'b0, NO_REPORT);
      add_row(8'h00, 1'b0, NO_REPORT);
      add_row(BYTE_FLAG, 1'b1, report_of(STATUS_TOO_SHORT, 16'd1, 16'd0));
      add_row(BYTE_ESCAPE, 1'b0, NO_REPORT);
      add_row(BYTE_FLAG, 1'b1, report_of(STATUS_ESCAPE_END, 16'd2, 16'd0));
      add_row(BYTE_SUBSTITUTE, 1'b0, NO_REPORT);
      add_row(8'h55, 1'b0, NO_REPORT);
      add_row(BYTE_CANCEL, 1'b0, NO_REPORT);
      add_row(BYTE_XOFF, 1'b0, NO_REPORT);
      add_row(8'h00, 1'b0, NO_REPORT);
      add_row(8'h00, 1'b0, NO_REPORT);
      add_row(8'h00, 1'b0, NO_REPORT);
      add_row(BYTE_FLAG, 1'b1, report_of(STATUS_CRC_ERROR, 16'd3, 16'd1));
      add_row(8'hFF, 1'b0, NO_REPORT);
      add_row(8'hFF, 1'b0, NO_REPORT);
      add_row(8'h00, 1'b0, NO_REPORT);
      add_row(BYTE_FLAG, 1'b1, report_of(STATUS_BAD_CONTROL, 16'd4, 16'd1));
      add_row(CTL_RST, 1'b0, NO_REPORT);
      add_row(8'h38, 1'b0, NO_REPORT);
      add_row(8'hBC, 1'b0, NO_REPORT);
      add_row(BYTE_FLAG, 1'b0, NO_REPORT);
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_line_byte(row.line_byte, row.typed, row.want);
      end
      wait_all_results();

      for (int phase = 0; phase < 6; phase++) begin
         req_idle_pct = 26;
         rsp_idle_pct = 26;
         case (phase)
            0: phase_seed = CRC_SEED_INIT;
            1: begin
               phase_seed   = 16'h0000;
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
            2: phase_seed = 16'($urandom);
            3: phase_seed = 16'($urandom);
            4: phase_seed = 16'h8000;
            default: phase_seed = 16'h7FFF;
         endcase
         write_crc_seed(phase_seed);
         seed_settings++;
         send_line_byte(BYTE_CANCEL, 1'b0, NO_REPORT);
         if (phase == 2) hold_off_request = 1'b1;
         phase_end = line_bytes_sent + PHASE_ITEMS;
         paused    = 1'b0;
         while (line_bytes_sent < phase_end) begin
            send_frame();
            if (phase == 3 && !paused && line_bytes_sent > phase_end - PHASE_ITEMS / 2) begin
               wait_all_results();
               paused = 1'b1;
            end
         end
         wait_all_results();
      end

      $display("Ran %0d line bytes under %0d CRC seeds: %0d results checked, %0d reports.",
               line_bytes_sent, seed_settings, results_checked, reports_checked);
      if (failures == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

@@ ash_frame_receiver.f @@
hw/rtl/afr_pkg.sv
hw/rtl/afr_channels.sv
hw/rtl/afr_frame_core.sv
hw/rtl/ash_frame_receiver.sv
sim/ash_frame_receiver_test.sv
